>>> hdl/concentric_square_to_disk_map_macros.svh
// Assertion macros used by the checker file of the concentric disk map.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef CONCENTRIC_SQUARE_TO_DISK_MAP_MACROS_SVH
`define CONCENTRIC_SQUARE_TO_DISK_MAP_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define CSDM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// The antecedent at one edge implies the consequent at the next edge.
`define CSDM_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent at the same edge, outside reset.
`define CSDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/csdm_pkg.sv
// Package of the concentric square-to-disk map: constants, the arctangent
// table and the pipeline payload types. Depends on nothing.
package csdm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_LIMIT   = 24;
  localparam int STEPS        = (CORDIC_STEPS > STEP_LIMIT) ? STEP_LIMIT : CORDIC_STEPS;
  localparam int DIV_CELLS    = 30;

  localparam longint KINF_Q30     = 64'd652032874;
  localparam longint KINF_2_3_Q30 = 64'd434688583;
  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] GAIN_Q30 = 31'(KINF_Q30 + (KINF_2_3_Q30 >> (2 * STEPS)));

  localparam logic [1:0] BASE_0 = 2'd0;
  localparam logic [1:0] BASE_2 = 2'd1;
  localparam logic [1:0] BASE_4 = 2'd2;
  localparam logic [1:0] BASE_6 = 2'd3;

  localparam logic signed [35:0] OUT_MAX = 36'sd32767;

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] r;
    logic [30:0] q;
    logic        neg;
    logic [1:0]  base;
    logic        ctr;
  } div_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         base;
    logic               ctr;
  } cord_t;

  // atan(2^-i) in Q0.30, truncated.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd843314856;
      5'd1:  a = 30'd497837829;
      5'd2:  a = 30'd263043836;
      5'd3:  a = 30'd133525158;
      5'd4:  a = 30'd67021686;
      5'd5:  a = 30'd33543515;
      5'd6:  a = 30'd16775850;
      5'd7:  a = 30'd8388437;
      5'd8:  a = 30'd4194282;
      5'd9:  a = 30'd2097149;
      5'd10: a = 30'd1048575;
      5'd11: a = 30'd524287;
      5'd12: a = 30'd262143;
      5'd13: a = 30'd131071;
      5'd14: a = 30'd65535;
      5'd15: a = 30'd32767;
      5'd16: a = 30'd16383;
      5'd17: a = 30'd8191;
      5'd18: a = 30'd4095;
      5'd19: a = 30'd2047;
      5'd20: a = 30'd1023;
      5'd21: a = 30'd511;
      5'd22: a = 30'd255;
      5'd23: a = 30'd127;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/concentric_square_to_disk_map.sv
// Concentric square-to-disk map: one transaction per cycle while the output is
// not stalled. A result passes, in order, the front stage, the 30-cell quotient
// chain, the multiply stage, the CORDIC cell row and the output register.
// Each stage holds while its successor is full and stalled, so bubbles close.
// Synchronous active-low reset empties every stage; payload is not reset.
module concentric_square_to_disk_map (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_square_u,
  input  logic [15:0]        in_square_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_disk_x,
  output logic signed [15:0] out_disk_y
);

  localparam int NDIV = csdm_pkg::DIV_CELLS;
  localparam int NCOR = csdm_pkg::STEPS;

  logic           div_vld [0:NDIV];
  csdm_pkg::div_t div_d   [0:NDIV];
  logic           div_rdy [0:NDIV+1];

  logic            cor_vld [0:NCOR];
  csdm_pkg::cord_t cor_d   [0:NCOR];
  logic            cor_rdy [0:NCOR+1];

  // Front stage: wedge selection and first quotient bit.
  logic signed [16:0] sx, sy, r_s, oth;
  logic [1:0]         base;
  logic [15:0]        r_u, mag;
  logic               ge0;
  csdm_pkg::div_t     front_nxt;

  assign sx = signed'({1'b0, in_square_u}) - 17'sd32768;
  assign sy = signed'({1'b0, in_square_v}) - 17'sd32768;

  always_comb begin
    if (sx >= -sy) begin
      if (sx > sy) begin
        r_s = sx;  oth = sy;  base = csdm_pkg::BASE_0;
      end else begin
        r_s = sy;  oth = -sx; base = csdm_pkg::BASE_2;
      end
    end else begin
      if (sx <= sy) begin
        r_s = -sx; oth = -sy; base = csdm_pkg::BASE_4;
      end else begin
        r_s = -sy; oth = sx;  base = csdm_pkg::BASE_6;
      end
    end
  end

  assign r_u = r_s[15:0];
  assign mag = oth[16] ? 16'(-oth) : oth[15:0];
  assign ge0 = mag >= r_u;

  always_comb begin
    front_nxt.rem  = ge0 ? 17'({1'b0, mag} - {1'b0, r_u}) : {1'b0, mag};
    front_nxt.r    = r_u;
    front_nxt.q    = {30'd0, ge0};
    front_nxt.neg  = oth[16];
    front_nxt.base = base;
    front_nxt.ctr  = (sx == 17'sd0) && (sy == 17'sd0);
  end

  assign div_rdy[0] = !div_vld[0] || div_rdy[1];
  assign in_stall   = !div_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld[0] <= 1'b0;
    end else if (div_rdy[0]) begin
      div_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_rdy[0]) begin
      div_d[0] <= front_nxt;
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    csdm_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (div_vld[k]),
      .in_data (div_d[k]),
      .nxt_rdy (div_rdy[k+2]),
      .rdy     (div_rdy[k+1]),
      .vld_r   (div_vld[k+1]),
      .data_r  (div_d[k+1])
    );
  end

  // Multiply stage: angle scaling by pi/4 and gain-corrected start vector.
  logic [60:0]     ang_prod;
  logic [30:0]     ang_a;
  logic [46:0]     x_prod;
  csdm_pkg::cord_t mul_nxt;

  assign ang_prod = {30'd0, div_d[NDIV].q} * {31'd0, csdm_pkg::PI4_Q30} + (61'd1 << 29);
  assign ang_a    = ang_prod[60:30];
  assign x_prod   = {31'd0, div_d[NDIV].r} * {16'd0, csdm_pkg::GAIN_Q30};

  always_comb begin
    mul_nxt.x    = signed'({2'b00, x_prod[46:15]});
    mul_nxt.y    = 34'sd0;
    mul_nxt.z    = div_d[NDIV].neg ? -signed'({2'b00, ang_a}) : signed'({2'b00, ang_a});
    mul_nxt.base = div_d[NDIV].base;
    mul_nxt.ctr  = div_d[NDIV].ctr;
  end

  assign div_rdy[NDIV+1] = cor_rdy[0];
  assign cor_rdy[0]      = !cor_vld[0] || cor_rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cor_vld[0] <= 1'b0;
    end else if (cor_rdy[0]) begin
      cor_vld[0] <= div_vld[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (cor_rdy[0]) begin
      cor_d[0] <= mul_nxt;
    end
  end

  for (genvar i = 0; i < NCOR; i++) begin : g_cor
    csdm_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (5'(i)),
      .in_vld  (cor_vld[i]),
      .in_data (cor_d[i]),
      .nxt_rdy (cor_rdy[i+2]),
      .rdy     (cor_rdy[i+1]),
      .vld_r   (cor_vld[i+1]),
      .data_r  (cor_d[i+1])
    );
  end

  // Output stage: quarter-turn by wedge, rounding and saturation.
  logic signed [34:0] fx, fy, ex, ey;
  logic signed [35:0] rx, ry;
  logic signed [15:0] ox, oy;
  logic               out_valid_r;
  logic signed [15:0] out_disk_x_r, out_disk_y_r;

  assign ex = 35'(cor_d[NCOR].x);
  assign ey = 35'(cor_d[NCOR].y);

  always_comb begin
    case (cor_d[NCOR].base)
      csdm_pkg::BASE_2: begin fx = -ey; fy = ex;  end
      csdm_pkg::BASE_4: begin fx = -ex; fy = -ey; end
      csdm_pkg::BASE_6: begin fx = ey;  fy = -ex; end
      default:          begin fx = ex;  fy = ey;  end
    endcase
  end

  assign rx = (36'(fx) + 36'sd16384) >>> 15;
  assign ry = (36'(fy) + 36'sd16384) >>> 15;

  always_comb begin
    if (cor_d[NCOR].ctr) begin
      ox = 16'sd0;
    end else if (rx > csdm_pkg::OUT_MAX) begin
      ox = 16'sd32767;
    end else if (rx < -csdm_pkg::OUT_MAX) begin
      ox = -16'sd32767;
    end else begin
      ox = rx[15:0];
    end
    if (cor_d[NCOR].ctr) begin
      oy = 16'sd0;
    end else if (ry > csdm_pkg::OUT_MAX) begin
      oy = 16'sd32767;
    end else if (ry < -csdm_pkg::OUT_MAX) begin
      oy = -16'sd32767;
    end else begin
      oy = ry[15:0];
    end
  end

  assign cor_rdy[NCOR+1] = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cor_rdy[NCOR+1]) begin
      out_valid_r <= cor_vld[NCOR];
    end
  end

  always_ff @(posedge clk) begin
    if (cor_rdy[NCOR+1]) begin
      out_disk_x_r <= ox;
      out_disk_y_r <= oy;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_disk_x = out_disk_x_r;
  assign out_disk_y = out_disk_y_r;

endmodule

>>> hdl/csdm_div_cell.sv
// One restoring-division cell: produces one quotient bit of other/r.
// Depends on csdm_pkg.
module csdm_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  csdm_pkg::div_t in_data,
  input  logic           nxt_rdy,
  output logic           rdy,
  output logic           vld_r,
  output csdm_pkg::div_t data_r
);

  logic [17:0]    rem2;
  logic           ge;
  csdm_pkg::div_t data_nxt;

  assign rdy  = !vld_r || nxt_rdy;
  assign rem2 = {in_data.rem, 1'b0};
  assign ge   = rem2 >= {2'b00, in_data.r};

  always_comb begin
    data_nxt     = in_data;
    data_nxt.rem = ge ? 17'(rem2 - {2'b00, in_data.r}) : 17'(rem2);
    data_nxt.q   = {in_data.q[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/csdm_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift index per instance.
// Depends on csdm_pkg.
module csdm_cordic_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [4:0]      idx,
  input  logic            in_vld,
  input  csdm_pkg::cord_t in_data,
  input  logic            nxt_rdy,
  output logic            rdy,
  output logic            vld_r,
  output csdm_pkg::cord_t data_r
);

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] ang;
  csdm_pkg::cord_t    data_nxt;

  assign rdy = !vld_r || nxt_rdy;
  // Arithmetic shifts round toward minus infinity.
  assign dx  = in_data.y >>> idx;
  assign dy  = in_data.x >>> idx;
  assign ang = signed'({3'b000, csdm_pkg::atan_q30(idx)});

  always_comb begin
    data_nxt = in_data;
    if (!in_data.z[32]) begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - ang;
    end else begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/csdm_checker.sv
// Port-level checker for the concentric disk map, bound to the top level.
// Depends on the assertion macros in concentric_square_to_disk_map_macros.svh.
`include "concentric_square_to_disk_map_macros.svh"

module csdm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [15:0]        in_square_u,
  input logic [15:0]        in_square_v,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_disk_x,
  input logic signed [15:0] out_disk_y
);

  // A waiting result keeps its place and value.
  `CSDM_ASSERT_IMPL(a_out_hold, clk, rst_n, $past(out_valid && out_stall) && $past(rst_n), out_valid && $stable(out_disk_x) && $stable(out_disk_y))
  // Saturation never lets the most negative code through.
  `CSDM_ASSERT_NEVER(a_x_range, clk, rst_n, out_valid && (out_disk_x == 16'sh8000))
  `CSDM_ASSERT_NEVER(a_y_range, clk, rst_n, out_valid && (out_disk_y == 16'sh8000))
  // Reset empties the pipeline, so no result follows it.
  `CSDM_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind concentric_square_to_disk_map csdm_checker u_csdm_checker (.*);
